[src/lcd_pkg.sv]
package lcd_pkg;

  localparam int LED_COUNT  = 18;
  localparam int FRAME_LEN  = 19;
  localparam int RING_COUNT = 6;
  localparam int LEG_COUNT  = 3;

  localparam int BYTE_W  = 8;
  localparam int MOD_W   = 9;
  localparam int IDX_W   = 5;
  localparam int LEG_W   = 2;
  localparam int RING_W  = 3;
  localparam int CFG_IDX_W = 2;

  // command field of the code byte
  localparam logic [1:0] CMD_SET_LED  = 2'd0;
  localparam logic [1:0] CMD_SET_LEG  = 2'd1;
  localparam logic [1:0] CMD_SET_RING = 2'd2;
  localparam logic [1:0] CMD_DELAY    = 2'd3;

  localparam logic [2:0] LEG_CODE_CLEAR = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_DELAY = 2'd3;

  localparam logic [MOD_W-1:0] MODULUS_RST = 9'd10;

  localparam logic [IDX_W-1:0] DELAY_IDX  = IDX_W'(LED_COUNT);
  localparam logic [IDX_W-1:0] FRAME_DONE = IDX_W'(FRAME_LEN);
  localparam logic [RING_W-1:0] RING_LAST = RING_W'(RING_COUNT - 1);

  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
  } lcd_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  register_index;
    logic [BYTE_W-1:0] register_value;
    logic              frame_end;
  } lcd_out_t;

  // decoded command handed to the frame sequencer
  typedef struct packed {
    logic                 clear;
    logic [LEG_COUNT-1:0] leg_sel;
    logic                 all_rings;
    logic [RING_W-1:0]    ring;
    logic [BYTE_W-1:0]    level;
    logic [BYTE_W-1:0]    delay;
  } lcd_cmd_t;

  // legs selected by leg codes 0..6; the clear code selects none
  function automatic logic [LEG_COUNT-1:0] leg_mask(input logic [2:0] code);
    logic [LEG_COUNT-1:0] m;
    case (code)
      3'd0:    m = 3'b001;
      3'd1:    m = 3'b010;
      3'd2:    m = 3'b100;
      3'd3:    m = 3'b011;
      3'd4:    m = 3'b101;
      3'd5:    m = 3'b110;
      3'd6:    m = 3'b111;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

[src/lcd_ram.sv]
module lcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/lcd_rem_div.sv]
module lcd_rem_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lcd_pkg::BYTE_W-1:0] dividend,
  input  logic [lcd_pkg::MOD_W-1:0]  divisor,
  output logic                     done,
  output logic [lcd_pkg::BYTE_W-1:0] rem
);
  import lcd_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] dvd_r, dvd_nxt;
  logic [MOD_W-1:0]  div_r, div_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [MOD_W-1:0]  part;

  // one quotient bit a cycle, restoring; a zero divisor leaves the dividend
  always_comb begin
    part     = {rem_r[BYTE_W-1:0], dvd_r[BYTE_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd7;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (part >= div_r) ? part - div_r : part;
      dvd_nxt = {dvd_r[BYTE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[BYTE_W-1:0];

  // partial remainder never outgrows the byte once a step resolves
  a_rem_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r[MOD_W-1] == 1'b0))
    else $error("remainder exceeds byte");

endmodule

[src/lcd_frame_seq.sv]
module lcd_frame_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lcd_pkg::lcd_cmd_t cmd,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output lcd_pkg::lcd_out_t out_data
);
  import lcd_pkg::*;

  lcd_cmd_t              cmd_r, cmd_nxt;
  logic                  busy_r, busy_nxt;
  logic [IDX_W-1:0]      iss_idx_r, iss_idx_nxt;
  logic [LEG_W-1:0]      iss_leg_r, iss_leg_nxt;
  logic [RING_W-1:0]     iss_ring_r, iss_ring_nxt;
  logic                  s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]      s1_idx_r, s1_idx_nxt;
  logic [LEG_W-1:0]      s1_leg_r, s1_leg_nxt;
  logic [RING_W-1:0]     s1_ring_r, s1_ring_nxt;
  logic [LED_COUNT-1:0]  vld_r, vld_nxt;
  logic                  out_vld_r, out_vld_nxt;
  lcd_out_t              out_r, out_nxt;

  logic                  adv, issue, rd_en, wr_en, s1_led;
  logic [BYTE_W-1:0]     rdata, old_val;

  lcd_ram #(.WIDTH(BYTE_W), .DEPTH(LED_COUNT)) u_levels (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx_r),
    .wdata (cmd_r.level),
    .re    (rd_en),
    .raddr (iss_idx_r),
    .rdata (rdata)
  );

  always_comb begin
    adv    = !out_vld_r || out_ready;
    issue  = busy_r && (iss_idx_r != FRAME_DONE) && adv;
    rd_en  = issue && (iss_idx_r != DELAY_IDX);
    s1_led = s1_vld_r && (s1_idx_r != DELAY_IDX);
    wr_en  = adv && s1_led && cmd_r.leg_sel[s1_leg_r]
             && (cmd_r.all_rings || (s1_ring_r == cmd_r.ring));
    old_val = (s1_led && vld_r[s1_idx_r]) ? rdata : '0;

    cmd_nxt      = cmd_r;
    busy_nxt     = busy_r;
    iss_idx_nxt  = iss_idx_r;
    iss_leg_nxt  = iss_leg_r;
    iss_ring_nxt = iss_ring_r;
    s1_vld_nxt   = s1_vld_r;
    s1_idx_nxt   = s1_idx_r;
    s1_leg_nxt   = s1_leg_r;
    s1_ring_nxt  = s1_ring_r;
    vld_nxt      = vld_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;

    if (start) begin
      cmd_nxt      = cmd;
      busy_nxt     = 1'b1;
      iss_idx_nxt  = '0;
      iss_leg_nxt  = '0;
      iss_ring_nxt = '0;
      if (cmd.clear) begin
        vld_nxt = '0;
      end
      // drop the last word of the previous frame once it is taken
      if (out_ready) begin
        out_vld_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (adv) begin
        // retire the word in stage one into the output register
        if (s1_vld_r) begin
          out_vld_nxt                = 1'b1;
          out_nxt.register_index     = s1_idx_r;
          out_nxt.frame_end          = !s1_led;
          if (!s1_led) begin
            out_nxt.register_value = cmd_r.delay;
          end else if (wr_en) begin
            out_nxt.register_value = cmd_r.level;
          end else begin
            out_nxt.register_value = old_val;
          end
        end else if (out_ready) begin
          out_vld_nxt = 1'b0;
        end
        if (wr_en) begin
          vld_nxt[s1_idx_r] = 1'b1;
        end
        // advance the read pointer
        s1_vld_nxt  = issue;
        s1_idx_nxt  = iss_idx_r;
        s1_leg_nxt  = iss_leg_r;
        s1_ring_nxt = iss_ring_r;
        if (issue) begin
          iss_idx_nxt = iss_idx_r + IDX_W'(1);
          if (iss_ring_r == RING_LAST) begin
            iss_ring_nxt = '0;
            iss_leg_nxt  = iss_leg_r + LEG_W'(1);
          end else begin
            iss_ring_nxt = iss_ring_r + RING_W'(1);
          end
        end
      end
      if ((iss_idx_r == FRAME_DONE) && !s1_vld_r) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      iss_idx_r  <= '0;
      iss_leg_r  <= '0;
      iss_ring_r <= '0;
      s1_vld_r   <= 1'b0;
      vld_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      iss_idx_r  <= iss_idx_nxt;
      iss_leg_r  <= iss_leg_nxt;
      iss_ring_r <= iss_ring_nxt;
      s1_vld_r   <= s1_vld_nxt;
      vld_r      <= vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    cmd_r     <= cmd_nxt;
    s1_idx_r  <= s1_idx_nxt;
    s1_leg_r  <= s1_leg_nxt;
    s1_ring_r <= s1_ring_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("frame started while sweep busy");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.frame_end == (out_r.register_index == DELAY_IDX)))
    else $error("frame_end not on delay word");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_idx_r <= FRAME_DONE) && (!s1_vld_r || (s1_idx_r <= DELAY_IDX)))
    else $error("sweep index out of range");

  a_ring_order: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> (s1_idx_r == IDX_W'(RING_COUNT) * IDX_W'(s1_leg_r) + IDX_W'(s1_ring_r)))
    else $error("leg and ring counters out of step with index");

endmodule

[src/led_command_decoder_top.sv]
// LED command decoder. Each accepted two-byte word is one command for an
// array of 18 LEDs (3 legs of 6 rings, LED index 6*leg+ring); after every
// command the block sends a frame of 19 output words: the 18 LED levels in
// index order, then the delay byte with frame_end set. The LED levels live in
// an 18-entry level memory with per-entry valid bits, so reset and the clear
// command zero all levels at once. Intensity is reduced modulo the
// intensity_modulus register by a serial remainder unit that takes 8 steps.
// A command then passes through these steps in order: the edge that takes it
// starts the remainder unit, whose steps and result register start the
// sweep; the first level read follows, the 19 words leave, the sweep goes
// idle, the control returns to idle, and the next command can be taken.
// Stalls on out_ready stretch the sweep. in_ready is high only between
// frames; the last word of a frame may still sit in the output register
// when the next command is taken.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only happen while the block is idle.
module led_command_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lcd_pkg::lcd_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lcd_pkg::lcd_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcd_pkg::MOD_W-1:0]      cfg_data
);
  import lcd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              big_endian_r, byte_mode_r, allow_delay_r;
  logic [MOD_W-1:0]  modulus_r;
  lcd_cmd_t          pend_r, pend_nxt;

  logic              in_acc;
  logic [BYTE_W-1:0] b_byte, code, raw;
  logic [1:0]        cmd_f;
  logic [2:0]        leg_f, ring_f;
  lcd_cmd_t          dec;
  lcd_cmd_t          seq_cmd;
  logic              div_done, seq_start, seq_busy;
  logic [BYTE_W-1:0] div_rem;

  assign cfg_ready = 1'b1;

  // config registers: written by index, idle-only by contract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r  <= 1'b0;
      byte_mode_r   <= 1'b0;
      modulus_r     <= MODULUS_RST;
      allow_delay_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIG_ENDIAN:  big_endian_r  <= cfg_data[0];
        CFG_BYTE_MODE:   byte_mode_r   <= cfg_data[0];
        CFG_MODULUS:     modulus_r     <= cfg_data;
        CFG_ALLOW_DELAY: allow_delay_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // split the word into code and intensity bytes and decode the command
  always_comb begin
    b_byte = byte_mode_r ? in_data.first_byte : in_data.second_byte;
    code   = big_endian_r ? b_byte : in_data.first_byte;
    raw    = big_endian_r ? in_data.first_byte : b_byte;
    cmd_f  = code[1:0];
    leg_f  = code[4:2];
    ring_f = code[7:5];

    dec           = '0;
    dec.ring      = (ring_f >= RING_W'(RING_COUNT)) ? ring_f - RING_W'(RING_COUNT) : ring_f;
    dec.level     = '0;
    case (cmd_f)
      CMD_SET_LED, CMD_SET_LEG: begin
        dec.clear     = (leg_f == LEG_CODE_CLEAR);
        dec.leg_sel   = leg_mask(leg_f);
        dec.all_rings = (cmd_f == CMD_SET_LEG);
      end
      CMD_SET_RING: begin
        dec.leg_sel = '1;
      end
      default: begin
        // delay command: no LED is touched
        dec.delay = allow_delay_r ? raw : '0;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // command waits here while the remainder unit works on its intensity
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    seq_start = 1'b0;
    seq_cmd   = pend_r;
    seq_cmd.level = div_rem;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pend_nxt  = dec;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          seq_start = 1'b1;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!seq_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pend_r <= pend_nxt;
  end

  lcd_rem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (raw),
    .divisor  (modulus_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  lcd_frame_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (seq_start),
    .cmd       (seq_cmd),
    .busy      (seq_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("remainder finished outside wait state");

  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_start |=> seq_busy && (state_r == ST_SWEEP))
    else $error("sweep did not start");

endmodule
